/* sv/swpg_pkg.sv */
// swpg_pkg: shared widths, defaults and controller/datapath command types
// for the swap permutation generator; no dependencies
package swpg_pkg;

    localparam int MAX_N_DEFAULT = 8;            // default number of positions held
    localparam int SIZE_W        = 4;            // width of size, level and loop counters
    localparam int ELEM_W        = 4;            // width of one permutation element
    localparam int WORD_W        = 32;           // packed permutation word
    localparam int INDEX_W       = 16;           // running permutation index
    localparam int PACK_SLOTS    = WORD_W / ELEM_W;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(5);

    // commands from controller to datapath
    typedef struct packed {
        logic accept;   // input beat taken: load identity or set up an advance
        logic rd1;      // fetch loop counter, read first swap operand
        logic rd2;      // read first operand of the second swap
        logic wr;       // complete a swap
        logic step;     // bump or climb the current level
        logic emit;     // load the output register
    } swpg_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic new_enum;    // restart requested or no enumeration in progress
        logic n_small;     // single element, nothing to advance
        logic fits;        // current level still has a swap to do
        logic climb_done;  // no level left above the current one
        logic out_free;    // output register can take a beat this cycle
    } swpg_stat_t;

endpackage

/* sv/swap_permutation_generator_core.sv */
// swap_permutation_generator_core: top level, joins the sequencer and the datapath
// depends on swpg_pkg, swpg_ctrl, swpg_datapath
//
// usage
//  - input channel (in_valid / in_stall / restart): each beat asks for one
//    permutation; restart = 1 starts over from the identity 1..n, restart = 0
//    asks for the next one in recursive swap-and-restore order
//  - output channel (out_valid / out_stall): one beat per request carrying
//    perm_word (element j in bits 4j+3..4j, unused positions zero), perm_index
//    and last (set on the final permutation, index n!-1)
//  - after a last beat, or after a size write, the next request starts over
//  - cfg_wr_en / cfg_wr_data write the element count n (1..MAX_N, zero runs
//    as one, larger values saturate); write only while the block is idle
//  - timing: a restart beat goes from the idle state straight to the output state;
//    an advance passes a read and a write state for each level it climbs, then
//    a read and a write for the second swap and the output state, set by the
//    swap unit that reads one store position per cycle
//  - one request is worked at a time; the next is taken as soon as the
//    result sits in the output register, even while out_stall holds it
//  - reset: no enumeration in progress, size 5, output channel empty
module swap_permutation_generator_core #(
    parameter int MAX_N = swpg_pkg::MAX_N_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // size register
    input  logic                            cfg_wr_en,
    input  logic [swpg_pkg::SIZE_W-1:0]     cfg_wr_data,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            restart,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [swpg_pkg::WORD_W-1:0]     perm_word,
    output logic [swpg_pkg::INDEX_W-1:0]    perm_index,
    output logic                            last
);

    swpg_pkg::swpg_cmd_t  cmd;
    swpg_pkg::swpg_stat_t stat;

    // sequencer: one step of the level walk per cycle; it holds while a result waits for the output register
    swpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage, swap unit and output register
    swpg_datapath #(
        .MAX_N (MAX_N)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .restart     (restart),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .perm_word   (perm_word),
        .perm_index  (perm_index),
        .last        (last)
    );

endmodule

/* sv/swpg_datapath.sv */
// swpg_datapath: permutation store, per-level loop counters, index count,
// size register and output register; uses swpg_pkg
module swpg_datapath #(
    parameter int MAX_N = swpg_pkg::MAX_N_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [swpg_pkg::SIZE_W-1:0]     cfg_wr_data,
    input  logic                            restart,
    input  logic                            out_stall,
    input  swpg_pkg::swpg_cmd_t             cmd,
    output swpg_pkg::swpg_stat_t            stat,
    output logic                            out_valid,
    output logic [swpg_pkg::WORD_W-1:0]     perm_word,
    output logic [swpg_pkg::INDEX_W-1:0]    perm_index,
    output logic                            last
);

    localparam int SW     = swpg_pkg::SIZE_W;
    localparam int EW     = swpg_pkg::ELEM_W;
    localparam int AW     = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int PACK_N = (MAX_N < swpg_pkg::PACK_SLOTS) ? MAX_N : swpg_pkg::PACK_SLOTS;
    localparam logic [SW-1:0] MAX_N_V = SW'(MAX_N);

    logic [EW-1:0]                  store_reg [MAX_N];
    logic [SW-1:0]                  lc_reg [MAX_N];
    logic [EW-1:0]                  tmp_reg;
    logic [SW-1:0]                  k_reg;
    logic [SW-1:0]                  i_reg;
    logic [SW-1:0]                  size_reg;
    logic                           started_reg;
    logic [swpg_pkg::INDEX_W-1:0]   count_reg;
    logic                           out_valid_reg;
    logic [swpg_pkg::WORD_W-1:0]    word_reg;
    logic [swpg_pkg::INDEX_W-1:0]   index_reg;
    logic                           last_reg;

    logic [SW-1:0]                  n_act;
    logic [SW-1:0]                  k_m1;
    logic [SW-1:0]                  lc_rd;
    logic [SW-1:0]                  i_fix;
    logic [SW-1:0]                  i_inc;
    logic [SW-1:0]                  a_pos;
    logic [SW-1:0]                  rd_pos;
    logic [EW-1:0]                  rd_data;
    logic                           new_enum;
    logic                           fits;
    logic                           fin;
    logic [swpg_pkg::WORD_W-1:0]    word;

    // size zero runs as one, oversize saturates
    always_comb
    begin
        if (size_reg == '0)
            n_act = SW'(1);
        else if (size_reg > MAX_N_V)
            n_act = MAX_N_V;
        else
            n_act = size_reg;
    end

    assign new_enum = restart || !started_reg;
    assign k_m1     = k_reg - SW'(1);
    assign lc_rd    = lc_reg[k_m1[AW-1:0]];
    assign i_fix    = (lc_rd == '0 || lc_rd > k_reg) ? SW'(1) : lc_rd;
    assign i_inc    = i_reg + SW'(1);
    assign fits     = (i_inc <= k_reg);
    assign a_pos    = k_reg - i_reg;

    // single read port on the store
    always_comb
    begin
        rd_pos = a_pos;
        if (cmd.rd1)
            rd_pos = k_reg - i_fix;
        else if (cmd.wr)
            rd_pos = k_m1;
        rd_data = store_reg[rd_pos[AW-1:0]];
    end

    // final arrangement: every level counter at its top
    always_comb
    begin
        fin = 1'b1;
        for (int j = 1; j < MAX_N; j++)
        begin
            if (SW'(j) < n_act && lc_reg[j] != SW'(j + 1))
                fin = 1'b0;
        end
    end

    always_comb
    begin
        word = '0;
        for (int j = 0; j < PACK_N; j++)
        begin
            if (SW'(j) < n_act)
                word[EW*j +: EW] = store_reg[j];
        end
    end

    always_comb
    begin
        stat.new_enum   = new_enum;
        stat.n_small    = (n_act < SW'(2));
        stat.fits       = fits;
        stat.climb_done = (k_reg >= n_act);
        stat.out_free   = !out_valid_reg || !out_stall;
    end

    // working storage
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            k_reg <= SW'(2);
            if (new_enum)
            begin
                for (int j = 0; j < MAX_N; j++)
                begin
                    store_reg[j] <= (SW'(j) < n_act) ? EW'(j + 1) : '0;
                    lc_reg[j]    <= (j >= 1 && SW'(j) < n_act) ? SW'(1) : '0;
                end
            end
        end
        if (cmd.rd1 || cmd.rd2)
            tmp_reg <= rd_data;
        if (cmd.rd1)
            i_reg <= i_fix;
        if (cmd.wr)
        begin
            for (int j = 0; j < MAX_N; j++)
            begin
                if (AW'(j) == k_m1[AW-1:0])
                    store_reg[j] <= tmp_reg;
                else if (AW'(j) == a_pos[AW-1:0])
                    store_reg[j] <= rd_data;
            end
        end
        if (cmd.step)
        begin
            if (fits)
            begin
                i_reg <= i_inc;
                for (int j = 1; j < MAX_N; j++)
                begin
                    if (AW'(j) == k_m1[AW-1:0])
                        lc_reg[j] <= i_inc;
                    else if (SW'(j) < k_m1)
                        lc_reg[j] <= SW'(1);
                end
            end
            else
            begin
                lc_reg[k_m1[AW-1:0]] <= k_reg;
                k_reg                <= k_reg + SW'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= swpg_pkg::SIZE_RESET;
            started_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                size_reg    <= cfg_wr_data;
                started_reg <= 1'b0;
            end
            if (cmd.accept)
            begin
                if (new_enum)
                begin
                    count_reg   <= '0;
                    started_reg <= 1'b1;
                end
                else
                    count_reg <= count_reg + 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (fin)
                    started_reg <= 1'b0;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            word_reg  <= word;
            index_reg <= count_reg;
            last_reg  <= fin;
        end
    end

    assign out_valid  = out_valid_reg;
    assign perm_word  = word_reg;
    assign perm_index = index_reg;
    assign last       = last_reg;

endmodule

/* sv/swpg_ctrl.sv */
// swpg_ctrl: sequencer that walks the recursion levels one swap at a time
// uses swpg_pkg command and status types
module swpg_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  swpg_pkg::swpg_stat_t    stat,
    output swpg_pkg::swpg_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD1,
        ST_WR1,
        ST_RD2,
        ST_WR2,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   accept;

    assign accept = in_valid && !in_stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = accept;
                if (accept)
                begin
                    if (stat.new_enum || stat.n_small)
                        state_next = ST_FIN;
                    else
                        state_next = ST_RD1;
                end
            end
            ST_RD1:
            begin
                cmd.rd1    = 1'b1;
                state_next = ST_WR1;
            end
            ST_WR1:
            begin
                cmd.wr   = 1'b1;
                cmd.step = 1'b1;
                if (stat.fits)
                    state_next = ST_RD2;
                else if (stat.climb_done)
                    state_next = ST_FIN;
                else
                    state_next = ST_RD1;
            end
            ST_RD2:
            begin
                cmd.rd2    = 1'b1;
                state_next = ST_WR2;
            end
            ST_WR2:
            begin
                cmd.wr     = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != ST_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

/* verif/swpg_checker.sv */
`timescale 1ns / 100ps
// swpg_checker: watches the size, request and result channels of the swap
// permutation generator, predicts each result beat and compares; uses swpg_pkg
module swpg_checker #(
    parameter int MAX_N = swpg_pkg::MAX_N_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [swpg_pkg::SIZE_W-1:0]     cfg_wr_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            restart,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [swpg_pkg::WORD_W-1:0]     perm_word,
    input  logic [swpg_pkg::INDEX_W-1:0]    perm_index,
    input  logic                            last,
    output int unsigned                     mismatch_count,
    output int unsigned                     pending,
    output int unsigned                     checked_count,
    output int unsigned                     final_count
);

    typedef struct {
        logic [swpg_pkg::WORD_W-1:0]  word;
        logic [swpg_pkg::INDEX_W-1:0] index;
        logic                         fin;
    } perm_beat_t;

    // shadow copy of the generator state
    logic [swpg_pkg::SIZE_W-1:0]  size_reg;
    logic [swpg_pkg::ELEM_W-1:0]  arrangement [MAX_N];
    logic [swpg_pkg::SIZE_W-1:0]  loop_ctr [MAX_N];
    logic [swpg_pkg::INDEX_W-1:0] perm_count;
    bit                           enumerating;

    perm_beat_t predicted_perms [$];

    function automatic int unsigned active_n();
        int unsigned n;
        n = size_reg;
        if (n < 1) n = 1;
        if (n > MAX_N) n = MAX_N;
        return n;
    endfunction

    function automatic void load_identity(int unsigned n);
        for (int j = 0; j < MAX_N; j++)
            arrangement[j] = (j < n) ? swpg_pkg::ELEM_W'(j + 1) : '0;
    endfunction

    function automatic void swap_positions(int unsigned a, int unsigned b);
        logic [swpg_pkg::ELEM_W-1:0] t;
        if (a >= MAX_N || b >= MAX_N) return;
        t = arrangement[a];
        arrangement[a] = arrangement[b];
        arrangement[b] = t;
    endfunction

    // one step of the swap-and-restore recursion, counters held per level
    function automatic void advance_one(int unsigned n);
        int unsigned i;
        for (int unsigned k = 2; k <= n; k++)
        begin
            i = loop_ctr[k-1];
            if (i < 1 || i > k) i = 1;
            swap_positions(k - i, k - 1);
            i++;
            if (i <= k)
            begin
                loop_ctr[k-1] = swpg_pkg::SIZE_W'(i);
                swap_positions(k - i, k - 1);
                for (int unsigned j = k - 1; j >= 2; j--)
                    loop_ctr[j-1] = swpg_pkg::SIZE_W'(1);
                return;
            end
            loop_ctr[k-1] = swpg_pkg::SIZE_W'(k);
        end
    endfunction

    function automatic perm_beat_t next_permutation(logic rs);
        perm_beat_t  beat;
        int unsigned n;
        n = active_n();
        if (rs || !enumerating)
        begin
            load_identity(n);
            for (int k = 0; k < MAX_N; k++) loop_ctr[k] = '0;
            for (int unsigned k = 2; k <= n; k++) loop_ctr[k-1] = swpg_pkg::SIZE_W'(1);
            perm_count  = '0;
            enumerating = 1'b1;
        end
        else
        begin
            advance_one(n);
            perm_count = perm_count + 1'b1;
        end
        beat.word = '0;
        for (int unsigned j = 0; j < n && j < swpg_pkg::PACK_SLOTS; j++)
            beat.word |= swpg_pkg::WORD_W'(arrangement[j]) << (swpg_pkg::ELEM_W * j);
        beat.index = perm_count;
        beat.fin   = 1'b1;
        for (int unsigned k = 2; k <= n; k++)
            if (loop_ctr[k-1] != swpg_pkg::SIZE_W'(k)) beat.fin = 1'b0;
        if (beat.fin) enumerating = 1'b0;
        return beat;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        perm_beat_t exp_beat;
        if (!rst_n)
        begin
            size_reg    = swpg_pkg::SIZE_RESET;
            load_identity(active_n());
            for (int k = 0; k < MAX_N; k++) loop_ctr[k] = '0;
            perm_count  = '0;
            enumerating = 1'b0;
            predicted_perms.delete();
            mismatch_count = 0;
            checked_count  = 0;
            final_count    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_perms.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got %h %0d %b",
                             $time, perm_word, perm_index, last);
                    mismatch_count++;
                end
                else
                begin
                    exp_beat = predicted_perms.pop_front();
                    checked_count++;
                    if (perm_word !== exp_beat.word)
                    begin
                        $display("%0t: perm_word expected %h got %h",
                                 $time, exp_beat.word, perm_word);
                        mismatch_count++;
                    end
                    if (perm_index !== exp_beat.index)
                    begin
                        $display("%0t: perm_index expected %0d got %0d",
                                 $time, exp_beat.index, perm_index);
                        mismatch_count++;
                    end
                    if (last !== exp_beat.fin)
                    begin
                        $display("%0t: last expected %b got %b", $time, exp_beat.fin, last);
                        mismatch_count++;
                    end
                    if (exp_beat.fin) final_count++;
                end
            end
            // a size write abandons the enumeration in progress
            if (cfg_wr_en)
            begin
                size_reg    = cfg_wr_data;
                enumerating = 1'b0;
            end
            if (in_valid && !in_stall)
                predicted_perms.push_back(next_permutation(restart));
        end
        pending = predicted_perms.size();
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for swap_permutation_generator_core
// depends on swpg_pkg, swap_permutation_generator_core and swpg_checker
module tb_top;

    localparam int MAX_N         = swpg_pkg::MAX_N_DEFAULT;
    localparam int RANDOM_ITEMS  = 550;
    // settle time covers the worst advance, which climbs every level, plus margin
    localparam int SETTLE_CYCLES = 2 * (MAX_N - 1) + 8;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [swpg_pkg::SIZE_W-1:0]    cfg_wr_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           restart;
    logic                           out_valid;
    logic                           out_stall;
    logic [swpg_pkg::WORD_W-1:0]    perm_word;
    logic [swpg_pkg::INDEX_W-1:0]   perm_index;
    logic                           last;

    int unsigned mismatch_count;
    int unsigned pending;
    int unsigned checked_count;
    int unsigned final_count;

    int unsigned sent_count;
    int unsigned size_writes;
    bit          calm;   // no gaps and no stalls while set

    swap_permutation_generator_core #(.MAX_N(MAX_N)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .perm_word   (perm_word),
        .perm_index  (perm_index),
        .last        (last)
    );

    swpg_checker #(.MAX_N(MAX_N)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .perm_word      (perm_word),
        .perm_index     (perm_index),
        .last           (last),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .checked_count  (checked_count),
        .final_count    (final_count)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side back-pressure: runs of stall and no stall, mostly short
    initial
    begin
        int unsigned run_left;
        run_left  = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                out_stall <= 1'b0;
                run_left  = 0;
            end
            else if (run_left == 0)
            begin
                // stall about a third of the time, long stalls rare
                if ($urandom_range(0, 2) == 0)
                begin
                    out_stall <= 1'b1;
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
                end
                else
                begin
                    out_stall <= 1'b0;
                    run_left = $urandom_range(1, 6);
                end
            end
            else
            begin
                run_left--;
            end
        end
    end

    // one request beat: optional idle gap, then hold until taken
    task automatic issue(input logic rs);
        int unsigned gap;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 60);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            restart  <= 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        // payload stays put until the beat is taken
        do @(posedge clk); while (in_stall);
        sent_count++;
    endtask

    // stop sending and wait until every predicted result has come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // size register is only written with the block idle
    task automatic write_size(input logic [swpg_pkg::SIZE_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        size_writes++;
    endtask

    initial
    begin
        int unsigned n;
        int unsigned eff;
        int unsigned span;
        int unsigned len;
        int unsigned r;
        bit          first;

        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        restart     = 1'b0;
        sent_count  = 0;
        size_writes = 0;
        calm        = 1'b0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // reset size 5, first request with no enumeration running acts as restart
        issue(1'b0);
        issue(1'b0);
        issue(1'b0);
        issue(1'b1);
        issue(1'b0);
        // single element: identity only, always last, repeated requests restart
        write_size(swpg_pkg::SIZE_W'(1));
        issue(1'b0);
        issue(1'b0);
        issue(1'b1);
        // zero runs as one element
        write_size(swpg_pkg::SIZE_W'(0));
        issue(1'b0);
        // all ones saturates to the full width of the store
        write_size(swpg_pkg::SIZE_W'(15));
        issue(1'b0);
        issue(1'b0);
        issue(1'b0);
        // two elements: reach last, then the next request wraps to identity
        write_size(swpg_pkg::SIZE_W'(2));
        issue(1'b0);
        issue(1'b0);
        issue(1'b0);
        issue(1'b1);
        // three elements partway, then a size write abandons the enumeration
        write_size(swpg_pkg::SIZE_W'(3));
        issue(1'b0);
        issue(1'b0);
        issue(1'b0);
        write_size(swpg_pkg::SIZE_W'(4));
        issue(1'b0);
        issue(1'b0);
        write_size(swpg_pkg::SIZE_W'(8));
        issue(1'b0);
        issue(1'b0);

        // ---- random part ----
        // mostly clean runs through whole enumerations, with sporadic restarts
        first = 1'b1;
        while (sent_count < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (first)
                n = 5;
            else if (r < 70)
                n = $urandom_range(1, 5);
            else if (r < 88)
                n = $urandom_range(6, 8);
            else if (r < 94)
                n = 0;
            else
                n = $urandom_range(9, 15);
            write_size(swpg_pkg::SIZE_W'(n));

            eff = (n < 1) ? 1 : (n > MAX_N) ? MAX_N : n;
            span = 1;
            for (int unsigned k = 2; k <= eff; k++) span = span * k;

            // first phase walks all of 5! and wraps
            if (first)
                len = span + 3;
            else if (eff <= 4)
                len = span * $urandom_range(1, 3) + $urandom_range(0, 2);
            else if (eff == 5)
                len = $urandom_range(20, 130);
            else
                len = $urandom_range(10, 60);

            calm = ($urandom_range(0, 3) == 0);
            for (int unsigned i = 0; i < len && sent_count < RANDOM_ITEMS; i++)
            begin
                issue(($urandom_range(0, 29) == 0) ? 1'b1 : 1'b0);
                // now and then hold off until the pipe is empty mid-enumeration
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
            calm  = 1'b0;
            first = 1'b0;
        end

        drain();
        $display("%0d requests sent over %0d size settings", sent_count, size_writes);
        $display("%0d result beats checked, %0d of them final permutations",
                 checked_count, final_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
sv/swpg_pkg.sv
sv/swpg_datapath.sv
sv/swpg_ctrl.sv
sv/swap_permutation_generator_core.sv
verif/swpg_checker.sv
verif/tb_top.sv
